@@ hdl/kpm_pkg.sv @@
// Shared types and constants for the keyword prefix matcher.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package kpm_pkg;

   localparam int KIND_W = 2;
   localparam int SLOT_W = 4;
   localparam int POS_W  = 4;
   localparam int CHAR_W = 8;
   localparam int LEN_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_CHAR = 2'd0,
      KIND_SET_LEN   = 2'd1,
      KIND_RESTART   = 2'd2,
      KIND_MATCH     = 2'd3
   } kind_type;

endpackage

`default_nettype wire

@@ hdl/kpm_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on kpm_pkg for the field widths.
`default_nettype none

interface kpm_req_if
   import kpm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SLOT_W-1:0] slot;
   logic [POS_W-1:0]  position;
   logic [CHAR_W-1:0] character;
   logic [LEN_W-1:0]  length;

   modport source (output valid, kind, slot, position, character, length, input ready);
   modport sink   (input valid, kind, slot, position, character, length, output ready);
endinterface

interface kpm_rsp_if
   import kpm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              found;
   logic              no_match;
   logic [SLOT_W-1:0] keyword_slot;

   modport source (output valid, found, no_match, keyword_slot, input ready);
   modport sink   (input valid, found, no_match, keyword_slot, output ready);
endinterface

`default_nettype wire

@@ hdl/kpm_char_bank.sv @@
// Character memory of one keyword slot with a registered read port.
// A write to the address being read is forwarded into the read register.
`default_nettype none

module kpm_char_bank
   import kpm_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [CHAR_W-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [CHAR_W-1:0]                        rd_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/keyword_prefix_matcher_core.sv @@
// Keyword prefix matcher: every table slot is compared with the stream in parallel.
// A request word is held in the input register and its response word in the result register; one word
// is accepted per cycle, limited only by the response side taking its words.
// Reset is synchronous and clears the slot lengths, live mask, position, flags and
// valid bits; the character table is undefined until loaded.
// Depends on kpm_pkg, kpm_if and kpm_char_bank.
`default_nettype none

module keyword_prefix_matcher_core
   import kpm_pkg::*;
#(
   parameter int NUM_KEYWORDS    = 16,
   parameter int MAX_KEYWORD_LEN = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   kpm_req_if.sink    req_if,
   kpm_rsp_if.source  rsp_if
);

   localparam int SLOT_IW = NUM_KEYWORDS > 1 ? $clog2(NUM_KEYWORDS) : 1;
   localparam int CHAR_IW = MAX_KEYWORD_LEN > 1 ? $clog2(MAX_KEYWORD_LEN) : 1;
   localparam int KLEN_W  = $clog2(MAX_KEYWORD_LEN + 1);

   // Input register.
   logic              in_valid_ff;
   kind_type          in_kind_ff;
   logic [SLOT_W-1:0] in_slot_ff;
   logic [POS_W-1:0]  in_pos_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic [LEN_W-1:0]  in_len_ff;

   // Matcher state.
   logic [KLEN_W-1:0]       len_ff [NUM_KEYWORDS];
   logic [KLEN_W-1:0]       len_in [NUM_KEYWORDS];
   logic [NUM_KEYWORDS-1:0] live_ff, live_in;
   logic [KLEN_W-1:0]       pos_ff, pos_in;
   logic                    found_ff, found_in;
   logic                    reject_ff, reject_in;
   logic [SLOT_W-1:0]       fslot_ff, fslot_in;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic              rsp_reject_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   logic                    advance, fire, take;
   logic                    slot_ok, pos_ok;
   logic [KLEN_W-1:0]       pos_plus;
   logic [KLEN_W-1:0]       len_clamped;
   logic [NUM_KEYWORDS-1:0] char_we;
   logic [NUM_KEYWORDS-1:0] consumed;
   logic [NUM_KEYWORDS-1:0] survivors;
   logic [NUM_KEYWORDS-1:0] exact;
   logic                    single;
   logic [SLOT_IW-1:0]      hit_idx;
   logic [CHAR_W-1:0]       rd_char [NUM_KEYWORDS];

   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign fire          = in_valid_ff && advance;
   assign req_if.ready  = !in_valid_ff || advance;
   assign take          = req_if.valid && req_if.ready;

   assign slot_ok     = 32'(in_slot_ff) < NUM_KEYWORDS;
   assign pos_ok      = 32'(in_pos_ff) < MAX_KEYWORD_LEN;
   assign pos_plus    = KLEN_W'(pos_ff + 1'b1);
   assign len_clamped = (32'(in_len_ff) > MAX_KEYWORD_LEN) ? KLEN_W'(MAX_KEYWORD_LEN)
                                                           : KLEN_W'(in_len_ff);

   // Per-slot write enable and compare of the stream character against the character at the position.
   always_comb begin
      hit_idx = '0;
      for (int s = 0; s < NUM_KEYWORDS; s++) begin
         char_we[s]   = fire && (in_kind_ff == KIND_LOAD_CHAR) && slot_ok && pos_ok &&
                        (32'(in_slot_ff) == s);
         consumed[s]  = live_ff[s] && (len_ff[s] <= pos_ff);
         survivors[s] = live_ff[s] && (rd_char[s] == in_char_ff);
         exact[s]     = len_ff[s] == pos_plus;
         if (survivors[s]) begin
            hit_idx = hit_idx | SLOT_IW'(s);
         end
      end
      single = (survivors != '0) && ((survivors & (survivors - 1'b1)) == '0);
   end

   always_comb begin
      len_in    = len_ff;
      live_in   = live_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      reject_in = reject_ff;
      fslot_in  = fslot_ff;
      if (fire) begin
         case (in_kind_ff)
            KIND_LOAD_CHAR: begin
            end
            KIND_SET_LEN: begin
               if (slot_ok) begin
                  len_in[SLOT_IW'(in_slot_ff)] = len_clamped;
               end
            end
            KIND_RESTART: begin
               for (int s = 0; s < NUM_KEYWORDS; s++) begin
                  live_in[s] = len_ff[s] != '0;
               end
               pos_in    = '0;
               found_in  = 1'b0;
               reject_in = 1'b0;
               fslot_in  = '0;
            end
            KIND_MATCH: begin
               if (!reject_ff) begin
                  if ((live_ff == '0) || (consumed != '0)) begin
                     reject_in = 1'b1;
                  end else begin
                     live_in = survivors;
                     pos_in  = pos_plus;
                     if (survivors == '0) begin
                        reject_in = 1'b1;
                     end else if (single && ((survivors & exact) != '0)) begin
                        found_in = 1'b1;
                        fslot_in = SLOT_W'(hit_idx);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar g = 0; g < NUM_KEYWORDS; g++) begin : gen_bank
      kpm_char_bank #(
         .DEPTH (MAX_KEYWORD_LEN)
      ) u_bank (
         .clock   (clock),
         .wr_en   (char_we[g]),
         .wr_addr (CHAR_IW'(in_pos_ff)),
         .wr_data (in_char_ff),
         .rd_addr (CHAR_IW'(pos_in)),
         .rd_data (rd_char[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         live_ff      <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         reject_ff    <= 1'b0;
         fslot_ff     <= '0;
         for (int s = 0; s < NUM_KEYWORDS; s++) begin
            len_ff[s] <= '0;
         end
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         live_ff   <= live_in;
         pos_ff    <= pos_in;
         found_ff  <= found_in;
         reject_ff <= reject_in;
         fslot_ff  <= fslot_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_kind_ff <= kind_type'(req_if.kind);
         in_slot_ff <= req_if.slot;
         in_pos_ff  <= req_if.position;
         in_char_ff <= req_if.character;
         in_len_ff  <= req_if.length;
      end
      if (fire) begin
         rsp_found_ff  <= found_in;
         rsp_reject_ff <= reject_in;
         rsp_slot_ff   <= found_in ? fslot_in : '0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.no_match     = rsp_reject_ff;
   assign rsp_if.keyword_slot = rsp_slot_ff;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for keyword_prefix_matcher_core: drives load, set-length, restart and
// match words at random pace and checks every response word against a predictor.
// Depends on kpm_pkg, the kpm_if channel interfaces and the matcher RTL.
`default_nettype none

module testbench;
   import kpm_pkg::*;

   localparam int NUM_SLOTS    = 16;
   localparam int MAX_LEN      = 16;
   localparam int WORD_TARGET  = 1450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 150;
   localparam int CALM_FROM    = 1200;
   localparam int CALM_TO      = 1800;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic              found;
      logic              no_match;
      logic [SLOT_W-1:0] keyword_slot;
   } match_result_type;

   class match_scoreboard;
      bit [CHAR_W-1:0]    kw_chars [NUM_SLOTS][MAX_LEN];
      bit [LEN_W-1:0]     kw_lens [NUM_SLOTS];
      bit [NUM_SLOTS-1:0] live;
      bit [LEN_W-1:0]     match_pos;
      bit                 found;
      bit                 rejected;
      bit [SLOT_W-1:0]    hit_slot;
      match_result_type   awaited [$];
      int                 errors;

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function int outstanding();
         return awaited.size();
      endfunction

      function void consume_char(bit [CHAR_W-1:0] ch);
         bit [NUM_SLOTS-1:0] survivors = '0;
         int count = 0;
         int last = 0;
         if (rejected) return;
         if (live == '0) begin
            rejected = 1'b1;
            return;
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (live[s] && kw_lens[s] <= match_pos) begin
               rejected = 1'b1;
               return;
            end
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (live[s] && kw_chars[s][match_pos[POS_W-1:0]] == ch) begin
               survivors[s] = 1'b1;
               count++;
               last = s;
            end
         end
         live = survivors;
         match_pos++;
         if (count == 0) begin
            rejected = 1'b1;
            return;
         end
         if (count == 1 && kw_lens[last] == match_pos) begin
            found = 1'b1;
            hit_slot = SLOT_W'(last);
         end
      endfunction

      function void note_word(kind_type k, bit [SLOT_W-1:0] slot, bit [POS_W-1:0] pos,
                              bit [CHAR_W-1:0] ch, bit [LEN_W-1:0] len);
         match_result_type want;
         case (k)
            KIND_LOAD_CHAR: begin
               kw_chars[slot][pos] = ch;
            end
            KIND_SET_LEN: begin
               kw_lens[slot] = (len > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
            end
            KIND_RESTART: begin
               for (int s = 0; s < NUM_SLOTS; s++) live[s] = (kw_lens[s] != 0);
               match_pos = '0;
               found = 1'b0;
               rejected = 1'b0;
               hit_slot = '0;
            end
            default: begin
               consume_char(ch);
            end
         endcase
         want.found = found;
         want.no_match = rejected;
         want.keyword_slot = found ? hit_slot : '0;
         awaited = {awaited, want};
      endfunction

      task check_word(match_result_type got);
         match_result_type want;
         if (awaited.size() == 0) begin
            report("response word arrived with none outstanding");
            return;
         end
         want = awaited.pop_front();
         if (got.found !== want.found)
            report($sformatf("found got %b want %b", got.found, want.found));
         if (got.no_match !== want.no_match)
            report($sformatf("no_match got %b want %b", got.no_match,
                             want.no_match));
         if (got.keyword_slot !== want.keyword_slot)
            report($sformatf("keyword_slot got %0d want %0d", got.keyword_slot,
                             want.keyword_slot));
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   words_sent = 0;
   logic calm;
   match_scoreboard sb;

   bit [CHAR_W-1:0]  gen_chars [NUM_SLOTS][MAX_LEN];
   bit [MAX_LEN-1:0] gen_written [NUM_SLOTS];
   int               gen_len [NUM_SLOTS];

   kpm_req_if req_ch ();
   kpm_rsp_if rsp_ch ();

   keyword_prefix_matcher_core #(
      .NUM_KEYWORDS    (NUM_SLOTS),
      .MAX_KEYWORD_LEN (MAX_LEN)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_word(kind_type'(req_ch.kind), req_ch.slot, req_ch.position,
                         req_ch.character, req_ch.length);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_word('{rsp_ch.found, rsp_ch.no_match, rsp_ch.keyword_slot});
      end
   end

   // The response side stalls at random, once for a long stretch so the block fills up.
   initial begin
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && cycle_count >= HOLD_AT) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
      end
   end

   // Starts and ends at a falling edge.
   task automatic send_word(kind_type k, bit [SLOT_W-1:0] slot, bit [POS_W-1:0] pos,
                            bit [CHAR_W-1:0] ch, bit [LEN_W-1:0] len);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= k;
      req_ch.slot      <= slot;
      req_ch.position  <= pos;
      req_ch.character <= ch;
      req_ch.length    <= len;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic bit [CHAR_W-1:0] pick_char();
      if ($urandom_range(0, 99) < 70) return CHAR_W'("a" + $urandom_range(0, 3));
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   task automatic load_char(int slot, int pos, bit [CHAR_W-1:0] ch);
      gen_chars[slot][pos] = ch;
      gen_written[slot][pos] = 1'b1;
      send_word(KIND_LOAD_CHAR, SLOT_W'(slot), POS_W'(pos), ch, LEN_W'($urandom));
   endtask

   // A length is cut back so that it covers only characters that have been loaded.
   task automatic set_length(int slot, int len);
      int usable = 0;
      while (usable < MAX_LEN && gen_written[slot][usable]) usable++;
      if (((len > MAX_LEN) ? MAX_LEN : len) > usable) len = usable;
      gen_len[slot] = (len > MAX_LEN) ? MAX_LEN : len;
      send_word(KIND_SET_LEN, SLOT_W'(slot), POS_W'($urandom), CHAR_W'($urandom),
                LEN_W'(len));
   endtask

   task automatic restart_match();
      send_word(KIND_RESTART, SLOT_W'($urandom), POS_W'($urandom), CHAR_W'($urandom),
                LEN_W'($urandom));
   endtask

   task automatic match_char(bit [CHAR_W-1:0] ch);
      send_word(KIND_MATCH, SLOT_W'($urandom), POS_W'($urandom), ch, LEN_W'($urandom));
   endtask

   task automatic program_keyword(int slot, int len);
      for (int i = 0; i < ((len > MAX_LEN) ? MAX_LEN : len); i++)
         load_char(slot, i, pick_char());
      set_length(slot, len);
   endtask

   task automatic noise_word();
      case ($urandom_range(0, 3))
         0: load_char($urandom_range(0, 15), $urandom_range(0, 15), CHAR_W'($urandom));
         1: set_length($urandom_range(0, 15), $urandom_range(0, 31));
         2: restart_match();
         default: match_char(CHAR_W'($urandom));
      endcase
   endtask

   task automatic run_session();
      int target = -1;
      int choice;
      int n;
      restart_match();
      for (int t = 0; t < NUM_SLOTS && target < 0; t++) begin
         choice = $urandom_range(0, NUM_SLOTS - 1);
         if (gen_len[choice] != 0) target = choice;
      end
      n = (target < 0) ? $urandom_range(1, 3) : gen_len[target];
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 5) noise_word();
         if (target < 0 || $urandom_range(0, 99) < 8 || gen_len[target] <= i)
            match_char(pick_char());
         else
            match_char(gen_chars[target][i]);
      end
      repeat ($urandom_range(0, 2)) match_char(pick_char());
   endtask

   initial begin
      int r;
      sb = new;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = '0;
      req_ch.slot = '0;
      req_ch.position = '0;
      req_ch.character = '0;
      req_ch.length = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      match_char("a");
      restart_match();
      match_char(8'hff);
      load_char(0, 0, "i");
      load_char(0, 1, "f");
      set_length(0, 2);
      load_char(1, 0, "i");
      load_char(1, 1, "n");
      set_length(1, 2);
      load_char(15, 0, 8'hff);
      load_char(15, 15, 8'h00);
      set_length(15, 1);
      restart_match();
      match_char("i");
      match_char("f");
      match_char("x");
      restart_match();
      match_char(8'hff);
      restart_match();
      match_char("q");
      match_char("i");
      set_length(15, 0);
      restart_match();
      match_char("i");
      set_length(1, 0);
      match_char("n");

      for (int i = 0; i < 6; i++) program_keyword($urandom_range(0, 15), $urandom_range(1, 4));
      while (words_sent < WORD_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            r = $urandom_range(0, 99);
            if (r < 10) program_keyword($urandom_range(0, 15), $urandom_range(16, 31));
            else if (r < 20) set_length($urandom_range(0, 15), 0);
            else program_keyword($urandom_range(0, 15), $urandom_range(1, 5));
         end else if (r < 20) begin
            repeat ($urandom_range(1, 4)) noise_word();
         end else begin
            run_session();
         end
      end
      req_ch.valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
